[rtl/cplt_pkg.sv]
`default_nettype none
package cplt_pkg;
    localparam int LEASES_PER_CAMERA = 16;
    localparam int CAMERA_COUNT = 2;
    localparam int SLOTS = CAMERA_COUNT * LEASES_PER_CAMERA;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LEASE_W = $clog2(LEASES_PER_CAMERA);
    localparam int CNT_W = 5;
    localparam int EXP_W = 6;
    localparam int ENTRY_W = 64;

    localparam logic [1:0] OP_OPEN = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_REMOVED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [1:0] REG_EXPIRE = 2'd0;
    localparam logic [1:0] REG_WARM0 = 2'd1;
    localparam logic [1:0] REG_WARM1 = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] power_on_cmd;
        logic [1:0] power_off_cmd;
        logic [1:0] ready_mask;
        logic [1:0] powered_mask;
        logic [4:0] count_cam0;
        logic [4:0] count_cam1;
        logic [5:0] expired_count;
    } result_t;
endpackage
`default_nettype wire

[rtl/cplt_ram.sv]
`default_nettype none
module cplt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/camera_power_lease_table.sv]
// Camera power lease table.
// Requests enter on the s_ channel: tdata holds opcode [1:0], camera [2],
// client_id [34:3]. Each request gives one result on the m_ channel.
// A request walks the lease entries of its camera (a tick walks all of
// them) one per cycle through the entry memory, whose read is registered.
// After the scan the finish state forms the result and the out state adds
// the lease counts and hands the result on; an unused opcode skips the scan.
// The valid bits live in flip-flops, so reset clears every lease at once.
// Client ids and start times sit in the memory and are used only for
// valid entries.
// The result register holds a result until it is taken; while it waits
// the block does not accept a new request, so a stalled receiver stalls
// the sender.
// Registers (APB, byte address 4*i): expire_seconds, warmup_cam0,
// warmup_cam1. Reset values 600, 10 and 120.
`default_nettype none
module camera_power_lease_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // opcode, camera, client_id
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // status, power_on_cmd, power_off_cmd,
                                        // ready_mask, powered_mask, count_cam0,
                                        // count_cam1, expired_count
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cplt_pkg::*;

    logic [16:0] expire_reg;
    logic [15:0] warm_reg [2];
    logic [1:0] ridx;
    assign ridx = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expire_reg <= 17'd600;
            warm_reg[0] <= 16'd10;
            warm_reg[1] <= 16'd120;
        end else if (psel && penable && pwrite) begin
            if (ridx == REG_EXPIRE) expire_reg <= pwdata[16:0];
            if (ridx == REG_WARM0) warm_reg[0] <= pwdata[15:0];
            if (ridx == REG_WARM1) warm_reg[1] <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (ridx == REG_EXPIRE) prdata = {15'd0, expire_reg};
        else if (ridx == REG_WARM0) prdata = {16'd0, warm_reg[0]};
        else if (ridx == REG_WARM1) prdata = {16'd0, warm_reg[1]};
    end

    state_t state_reg, state_next;
    logic [1:0] op_reg;
    logic cam_reg;
    logic [31:0] id_reg;
    logic [SLOT_W:0] rptr_reg, rptr_next;
    logic rv_reg;
    logic [SLOT_W-1:0] rslot_reg;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [31:0] sec_reg, sec_next;
    logic [1:0] pow_reg, pow_next, wact_reg, wact_next;
    logic [15:0] wleft_reg [2];
    logic [15:0] wleft_next [2];
    logic found_reg, found_next, free_reg, free_next;
    logic [SLOT_W-1:0] fslot_reg, fslot_next, eslot_reg, eslot_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    result_t res_reg, res_next;
    logic mv_reg, mv_next;

    logic we;
    logic [SLOT_W-1:0] waddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [SLOT_W-1:0] raddr;
    logic [SLOT_W:0] last;

    assign raddr = rptr_reg[SLOT_W-1:0];

    cplt_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    function automatic logic [CNT_W-1:0] cnt(input logic [SLOTS-1:0] v, input int c);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < LEASES_PER_CAMERA; i++) begin
            n = n + CNT_W'(v[c*LEASES_PER_CAMERA+i]);
        end
        return n;
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata = {5'd0, res_reg.expired_count, res_reg.count_cam1, res_reg.count_cam0,
                      res_reg.powered_mask, res_reg.ready_mask, res_reg.power_off_cmd,
                      res_reg.power_on_cmd, res_reg.status};

    always_comb begin
        logic [31:0] age;
        logic [1:0] on, off, rdy;
        logic [2:0] st;
        logic c;
        state_next = state_reg;
        rptr_next = rptr_reg;
        valid_next = valid_reg;
        sec_next = sec_reg;
        pow_next = pow_reg;
        wact_next = wact_reg;
        wleft_next = wleft_reg;
        found_next = found_reg;
        free_next = free_reg;
        fslot_next = fslot_reg;
        eslot_next = eslot_reg;
        exp_next = exp_reg;
        res_next = res_reg;
        mv_next = mv_reg && !m_tready;
        we = 1'b0;
        waddr = fslot_reg;
        wdata = {sec_reg, id_reg};
        on = '0; off = '0; rdy = '0; st = ST_DONE;
        c = cam_reg;
        last = (op_reg == OP_TICK) ? (SLOT_W+1)'(SLOTS)
                                   : (SLOT_W+1)'({cam_reg, LEASE_W'(0)} + LEASES_PER_CAMERA);
        age = sec_reg - rdata[63:32];
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    found_next = 1'b0;
                    free_next = 1'b0;
                    exp_next = '0;
                    if (s_tdata[1:0] == OP_TICK) begin
                        sec_next = sec_reg + 32'd1;
                        rptr_next = '0;
                        state_next = S_SCAN;
                    end else if (s_tdata[1:0] == OP_OPEN || s_tdata[1:0] == OP_CLOSE) begin
                        rptr_next = (SLOT_W+1)'({s_tdata[2], LEASE_W'(0)});
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (rv_reg) begin
                    if (op_reg == OP_TICK) begin
                        if (valid_reg[rslot_reg] && age > {15'd0, expire_reg}) begin
                            valid_next[rslot_reg] = 1'b0;
                            exp_next = exp_reg + EXP_W'(1);
                        end
                    end else begin
                        if (!found_reg && valid_reg[rslot_reg] && rdata[31:0] == id_reg) begin
                            found_next = 1'b1;
                            fslot_next = rslot_reg;
                        end
                        if (!free_reg && !valid_reg[rslot_reg]) begin
                            free_next = 1'b1;
                            eslot_next = rslot_reg;
                        end
                    end
                end
                if (rptr_reg != last) begin
                    rptr_next = rptr_reg + (SLOT_W+1)'(1);
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (op_reg == OP_TICK) begin
                    for (int k = 0; k < CAMERA_COUNT; k++) begin
                        if (wact_reg[k]) begin
                            wleft_next[k] = wleft_reg[k] - 16'd1;
                            if (wleft_reg[k] == 16'd1) begin
                                wact_next[k] = 1'b0;
                                pow_next[k] = 1'b1;
                                rdy[k] = 1'b1;
                            end
                        end
                    end
                    for (int k = 0; k < CAMERA_COUNT; k++) begin
                        if (pow_next[k] && cnt(valid_reg, k) == '0) begin
                            pow_next[k] = 1'b0;
                            off[k] = 1'b1;
                        end
                    end
                end else if (op_reg == OP_CLOSE) begin
                    if (found_reg) begin
                        valid_next[fslot_reg] = 1'b0;
                        st = ST_REMOVED;
                    end else begin
                        st = ST_NOT_FOUND;
                    end
                end else if (op_reg == OP_OPEN) begin
                    if (found_reg) begin
                        we = 1'b1;
                        st = ST_REFRESHED;
                    end else if (free_reg) begin
                        we = 1'b1;
                        waddr = eslot_reg;
                        valid_next[eslot_reg] = 1'b1;
                        st = ST_ADDED;
                    end
                    if (st != ST_DONE && !pow_reg[c] && !wact_reg[c]) begin
                        on[c] = 1'b1;
                        if (warm_reg[c] == 16'd0) begin
                            pow_next[c] = 1'b1;
                            rdy[c] = 1'b1;
                        end else begin
                            wact_next[c] = 1'b1;
                            wleft_next[c] = warm_reg[c];
                        end
                    end
                end
                res_next.status = st;
                res_next.power_on_cmd = on;
                res_next.power_off_cmd = off;
                res_next.ready_mask = rdy;
                res_next.powered_mask = pow_next;
                res_next.count_cam0 = '0;
                res_next.count_cam1 = '0;
                res_next.expired_count = (op_reg == OP_TICK) ? exp_reg : '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                res_next.count_cam0 = cnt(valid_reg, 0);
                res_next.count_cam1 = cnt(valid_reg, 1);
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            sec_reg <= '0;
            pow_reg <= '0;
            wact_reg <= '0;
            wleft_reg[0] <= '0;
            wleft_reg[1] <= '0;
            mv_reg <= 1'b0;
            rv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            sec_reg <= sec_next;
            pow_reg <= pow_next;
            wact_reg <= wact_next;
            wleft_reg <= wleft_next;
            mv_reg <= mv_next;
            rv_reg <= (state_reg == S_SCAN) && (rptr_reg != last);
        end
    end

    always_ff @(posedge aclk) begin
        rptr_reg <= rptr_next;
        rslot_reg <= raddr;
        found_reg <= found_next;
        free_reg <= free_next;
        fslot_reg <= fslot_next;
        eslot_reg <= eslot_next;
        exp_reg <= exp_next;
        res_reg <= res_next;
        if (s_tvalid && s_tready) begin
            op_reg <= s_tdata[1:0];
            cam_reg <= s_tdata[2];
            id_reg <= s_tdata[34:3];
        end
    end
endmodule
`default_nettype wire

[rtl/cplt_checker.sv]
`default_nettype none
module cplt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");
    a_nooverlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken while result waits");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd4)
        else $error("bad status");
endmodule

bind camera_power_lease_table cplt_checker u_cplt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
